// ----- sv/ihrg_pkg.sv -----
// ----------------------------------------------------------------------------
// ihrg_pkg
// shared widths, entry kind codes and the row summary passed between the
// coupling pipeline and the flip emitter
// ----------------------------------------------------------------------------
package ihrg_pkg;

    localparam int ROW_W   = 16;
    localparam int SIDE_W  = 3;
    localparam int COUP_W  = 7;
    localparam int FIELD_W = 6;
    localparam int SQ_W    = 2 * SIDE_W;

    // side length after reset, before clamping to the configured maximum
    localparam int SIDE_RST = 4;

    localparam logic KIND_DIAG = 1'b0;
    localparam logic KIND_FLIP = 1'b1;

    typedef struct packed {
        logic [ROW_W-1:0]          row;
        logic [SIDE_W-1:0]         side;
        logic signed [COUP_W-1:0]  coupling;
        logic signed [FIELD_W-1:0] field;
    } t_row_info;

    typedef struct packed {
        logic      valid;
        t_row_info info;
    } t_row_xfer;

endpackage

// ----- sv/ihrg_in_if.sv -----
// ----------------------------------------------------------------------------
// ihrg_in_if
// valid/ready channel that carries one basis-state row index
// ----------------------------------------------------------------------------
interface ihrg_in_if import ihrg_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row_index;

    modport source (output valid, output row_index, input ready);
    modport sink   (input valid, input row_index, output ready);

endinterface

// ----- sv/ihrg_out_if.sv -----
// ----------------------------------------------------------------------------
// ihrg_out_if
// valid/ready channel that carries one hamiltonian matrix entry
// ----------------------------------------------------------------------------
interface ihrg_out_if import ihrg_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic [ROW_W-1:0]          column;
    logic                      entry_kind;
    logic signed [COUP_W-1:0]  coupling_value;
    logic signed [FIELD_W-1:0] field_value;
    logic                      last_of_row;

    modport source (
        output valid, output column, output entry_kind, output coupling_value,
        output field_value, output last_of_row, input ready
    );
    modport sink (
        input valid, input column, input entry_kind, input coupling_value,
        input field_value, input last_of_row, output ready
    );

endinterface

// ----- sv/ising_hamiltonian_row_generator_unit.sv -----
// ----------------------------------------------------------------------------
// ising_hamiltonian_row_generator_unit
// generates one row of the 2d periodic transverse-field ising hamiltonian
// ----------------------------------------------------------------------------
// usage
//   i_row carries one basis-state index per transaction (valid/ready).
//   o_res carries the row's entries: first the diagonal entry with its bond
//   sum and field value, then N = L*L spin-flip entries in ascending column
//   order; last_of_row marks the final one.
//   i_cfg_we / i_cfg_data write the lattice side L; out-of-range values are
//   clamped to 2..MAX_SIDE. write only while no row is in flight.
// flow
//   after acceptance a row passes pipeline stages 1 to 4 and the emitter row
//   register before its diagonal entry is loaded into the output register.
//   each row gives N+1 output entries; the flip emitter hands out one entry
//   per cycle while the receiver holds ready high, which sets the sustained row
//   rate, while the pipeline already takes the following rows behind it.
// reset and stall
//   reset (synchronous, active low) empties the pipeline and output register
//   and sets L to min(4, MAX_SIDE). with ready held low by the receiver the output
//   entry holds, emitter and pipeline stop in place, i_row.ready drops once full.
// ----------------------------------------------------------------------------
module ising_hamiltonian_row_generator_unit import ihrg_pkg::*; #(
    parameter int MAX_SIDE = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ihrg_in_if.sink           i_row,
    ihrg_out_if.source        o_res,
    input  logic              i_cfg_we,
    input  logic [SIDE_W-1:0] i_cfg_data
);

    // reset side, already inside the legal range for this build
    localparam int SIDE_INIT = (MAX_SIDE < SIDE_RST) ? MAX_SIDE : SIDE_RST;

    logic [SIDE_W-1:0] r_side;
    logic [SIDE_W-1:0] n_side;

    t_row_xfer w_xfer;
    logic      w_xfer_ready;

    // clamp the side once at the write, so downstream logic only sees 2..MAX_SIDE
    always_comb begin
        priority if (i_cfg_data < SIDE_W'(2)) begin
            n_side = SIDE_W'(2);
        end else if (i_cfg_data > SIDE_W'(MAX_SIDE)) begin
            n_side = SIDE_W'(MAX_SIDE);
        end else begin
            n_side = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= SIDE_W'(SIDE_INIT);
        end else if (i_cfg_we) begin
            r_side <= n_side;
        end
    end

    // masking, bond disagreement, counting, diagonal values
    ihrg_diag_pipe #(
        .MAX_SIDE (MAX_SIDE)
    ) u_diag_pipe (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_row        (i_row),
        .i_side       (r_side),
        .o_xfer       (w_xfer),
        .i_xfer_ready (w_xfer_ready)
    );

    // diagonal, then one flip entry per unstalled cycle into the output register
    ihrg_flip_emit #(
        .MAX_SIDE (MAX_SIDE)
    ) u_flip_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_xfer       (w_xfer),
        .o_xfer_ready (w_xfer_ready),
        .o_res        (o_res)
    );

endmodule

// ----- sv/ihrg_diag_pipe.sv -----
// ----------------------------------------------------------------------------
// ihrg_diag_pipe
// four-stage pipeline that masks the row, finds disagreeing bonds, counts
// them and forms the diagonal coupling and field values
// ----------------------------------------------------------------------------
module ihrg_diag_pipe import ihrg_pkg::*; #(
    parameter int MAX_SIDE = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ihrg_in_if.sink           i_row,
    input  logic [SIDE_W-1:0] i_side,
    output t_row_xfer         o_xfer,
    input  logic              i_xfer_ready
);

    localparam int MAX_N   = MAX_SIDE * MAX_SIDE;
    localparam int BV_W    = 2 * MAX_N;
    localparam int GS      = 16;
    localparam int NG      = (BV_W + GS - 1) / GS;
    localparam int PAD_W   = NG * GS;
    localparam int PART_W  = $clog2(GS + 1);
    localparam int DCNT_W  = $clog2(BV_W + 1);
    localparam int ONES_W  = $clog2(ROW_W + 1);
    localparam int ACC_W   = (DCNT_W + 2 > COUP_W) ? DCNT_W + 2 : COUP_W;
    localparam int FACC_W  = 8;

    // stage enables
    logic w_en1, w_en2, w_en3, w_en4;

    // stage 1: masked row
    logic              r1_v;
    logic [ROW_W-1:0]  r1_row;
    logic [SIDE_W-1:0] r1_side;
    logic [SQ_W-1:0]   w_n0;
    logic [ROW_W-1:0]  w_mask;

    // stage 2: bond disagreement vector and spin count
    logic              r2_v;
    logic [ROW_W-1:0]  r2_row;
    logic [SIDE_W-1:0] r2_side;
    logic [ONES_W-1:0] r2_ones;
    logic [BV_W-1:0]   r2_diff;
    logic [MAX_N-1:0]  w_rowv;
    logic [BV_W-1:0]   w_diff [2:MAX_SIDE];
    logic [BV_W-1:0]   n2_diff;
    logic [ONES_W-1:0] n2_ones;

    // stage 3: partial counts
    logic              r3_v;
    logic [ROW_W-1:0]  r3_row;
    logic [SIDE_W-1:0] r3_side;
    logic [ONES_W-1:0] r3_ones;
    logic [PART_W-1:0] r3_part [NG];
    logic [PART_W-1:0] n3_part [NG];
    logic [PAD_W-1:0]  w_dpad;

    // stage 4: diagonal values
    logic              r4_v;
    t_row_info         r4_info;
    logic [DCNT_W-1:0] w_dcnt;
    logic [SQ_W-1:0]   w_sq;
    logic [ACC_W-1:0]  w_bonds;
    logic [ACC_W-1:0]  w_coup;
    logic [FACC_W-1:0] w_fld;

    assign w_en4 = !r4_v || i_xfer_ready;
    assign w_en3 = !r3_v || w_en4;
    assign w_en2 = !r2_v || w_en3;
    assign w_en1 = !r1_v || w_en2;

    assign i_row.ready = w_en1;

    // stage 1
    assign w_n0 = SQ_W'(i_side) * SQ_W'(i_side);

    always_comb begin
        for (int k = 0; k < ROW_W; k++) begin
            w_mask[k] = SQ_W'(k) < w_n0;
        end
    end

    // stage 2: spins as a vector over all possible sites
    for (genvar k = 0; k < MAX_N; k++) begin : g_rowv
        if (k < ROW_W) begin : g_in
            assign w_rowv[k] = r1_row[k];
        end else begin : g_zero
            assign w_rowv[k] = 1'b0;
        end
    end

    // per side length, the right and down bond of each site with fixed wiring
    for (genvar sv = 2; sv <= MAX_SIDE; sv++) begin : g_side
        localparam int NN = sv * sv;
        for (genvar i = 0; i < MAX_N; i++) begin : g_site
            if (i < NN) begin : g_live
                localparam int Q     = i + 1;
                localparam int RIGHT = (Q % sv == 0) ? Q + 1 - sv : Q + 1;
                localparam int DOWN  = (Q + sv > NN) ? (Q + sv) % NN : Q + sv;
                // the two skips only trigger on a 2 x 2 lattice
                if (RIGHT != Q - 1) begin : g_r
                    assign w_diff[sv][2*i] = w_rowv[NN-Q] ^ w_rowv[NN-RIGHT];
                end else begin : g_rs
                    assign w_diff[sv][2*i] = 1'b0;
                end
                if (DOWN != Q - sv) begin : g_d
                    assign w_diff[sv][2*i+1] = w_rowv[NN-Q] ^ w_rowv[NN-DOWN];
                end else begin : g_ds
                    assign w_diff[sv][2*i+1] = 1'b0;
                end
            end else begin : g_dead
                assign w_diff[sv][2*i]   = 1'b0;
                assign w_diff[sv][2*i+1] = 1'b0;
            end
        end
    end

    always_comb begin
        n2_diff = '0;
        for (int sv = 2; sv <= MAX_SIDE; sv++) begin
            if (r1_side == SIDE_W'(sv)) begin
                n2_diff = w_diff[sv];
            end
        end
        n2_ones = '0;
        for (int k = 0; k < ROW_W; k++) begin
            n2_ones = n2_ones + ONES_W'(r1_row[k]);
        end
    end

    // stage 3
    assign w_dpad = PAD_W'(r2_diff);

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n3_part[g] = '0;
            for (int b = 0; b < GS; b++) begin
                n3_part[g] = n3_part[g] + PART_W'(w_dpad[g*GS+b]);
            end
        end
    end

    // stage 4
    always_comb begin
        w_dcnt = '0;
        for (int g = 0; g < NG; g++) begin
            w_dcnt = w_dcnt + DCNT_W'(r3_part[g]);
        end
    end

    assign w_sq    = SQ_W'(r3_side) * SQ_W'(r3_side);
    assign w_bonds = (r3_side == SIDE_W'(2)) ? ACC_W'(4) : ACC_W'({w_sq, 1'b0});
    assign w_coup  = w_bonds - ACC_W'({w_dcnt, 1'b0});
    assign w_fld   = FACC_W'(w_sq) - FACC_W'({r3_ones, 1'b0});

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (w_en1) r1_v <= i_row.valid;
            if (w_en2) r2_v <= r1_v;
            if (w_en3) r3_v <= r2_v;
            if (w_en4) r4_v <= r3_v;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_row  <= i_row.row_index & w_mask;
            r1_side <= i_side;
        end
        if (w_en2) begin
            r2_row  <= r1_row;
            r2_side <= r1_side;
            r2_ones <= n2_ones;
            r2_diff <= n2_diff;
        end
        if (w_en3) begin
            r3_row  <= r2_row;
            r3_side <= r2_side;
            r3_ones <= r2_ones;
            r3_part <= n3_part;
        end
        if (w_en4) begin
            r4_info.row      <= r3_row;
            r4_info.side     <= r3_side;
            r4_info.coupling <= w_coup[COUP_W-1:0];
            r4_info.field    <= w_fld[FIELD_W-1:0];
        end
    end

    assign o_xfer.valid = r4_v;
    assign o_xfer.info  = r4_info;

endmodule

// ----- sv/ihrg_flip_emit.sv -----
// ----------------------------------------------------------------------------
// ihrg_flip_emit
// expands one row summary into the diagonal entry and its spin-flip entries,
// one per cycle unless the output stalls, through a registered output stage
// ----------------------------------------------------------------------------
module ihrg_flip_emit import ihrg_pkg::*; #(
    parameter int MAX_SIDE = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_row_xfer i_xfer,
    output logic      o_xfer_ready,
    ihrg_out_if.source o_res
);

    localparam int MAX_N = MAX_SIDE * MAX_SIDE;

    logic                      r_busy;
    logic                      r_diag;
    logic [ROW_W-1:0]          r_row;
    logic signed [COUP_W-1:0]  r_coup;
    logic signed [FIELD_W-1:0] r_field;
    logic [MAX_N-1:0]          r_pa;   // set bits still to clear
    logic [MAX_N-1:0]          r_pb;   // clear bits still to set

    logic                      r_o_valid;
    logic [ROW_W-1:0]          r_o_column;
    logic                      r_o_kind;
    logic signed [COUP_W-1:0]  r_o_coup;
    logic signed [FIELD_W-1:0] r_o_field;
    logic                      r_o_last;

    logic             w_out_load, w_emit, w_take, w_last, w_pa_any;
    logic [MAX_N-1:0] w_pa_rev, w_rev_iso, w_hi, w_lo, w_flip;
    logic [MAX_N-1:0] w_pa_nxt, w_pb_nxt;
    logic [MAX_N-1:0] w_in_rowv, w_in_nmask;
    logic [ROW_W-1:0] w_flip16;
    logic [SQ_W-1:0]  w_in_n;

    // highest pending set bit through a reversed lowest-bit isolate
    for (genvar k = 0; k < MAX_N; k++) begin : g_rev
        assign w_pa_rev[k] = r_pa[MAX_N-1-k];
        assign w_hi[k]     = w_rev_iso[MAX_N-1-k];
    end

    for (genvar k = 0; k < ROW_W; k++) begin : g_flip16
        if (k < MAX_N) begin : g_in
            assign w_flip16[k] = w_flip[k];
        end else begin : g_zero
            assign w_flip16[k] = 1'b0;
        end
    end

    for (genvar k = 0; k < MAX_N; k++) begin : g_inrow
        if (k < ROW_W) begin : g_in
            assign w_in_rowv[k] = i_xfer.info.row[k];
        end else begin : g_zero
            assign w_in_rowv[k] = 1'b0;
        end
        assign w_in_nmask[k] = SQ_W'(k) < w_in_n;
    end

    assign w_in_n    = SQ_W'(i_xfer.info.side) * SQ_W'(i_xfer.info.side);
    assign w_rev_iso = w_pa_rev & (~w_pa_rev + MAX_N'(1));
    assign w_lo      = r_pb & (~r_pb + MAX_N'(1));
    assign w_pa_any  = |r_pa;
    assign w_flip    = w_pa_any ? w_hi : w_lo;
    assign w_pa_nxt  = r_pa & ~w_hi;
    assign w_pb_nxt  = r_pb & ~w_lo;

    always_comb begin
        priority if (r_diag) begin
            w_last = (r_pa == '0) && (r_pb == '0);
        end else if (w_pa_any) begin
            w_last = (w_pa_nxt == '0) && (r_pb == '0);
        end else begin
            w_last = (w_pb_nxt == '0);
        end
    end

    assign w_out_load   = !r_o_valid || o_res.ready;
    assign w_emit       = r_busy && w_out_load;
    assign o_xfer_ready = !r_busy || (w_emit && w_last);
    assign w_take       = i_xfer.valid && o_xfer_ready;

    // control, a new row wins over the end of the current one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_diag    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_out_load) r_o_valid <= r_busy;
            if (w_take) begin
                r_busy <= 1'b1;
                r_diag <= 1'b1;
            end else if (w_emit) begin
                r_diag <= 1'b0;
                if (w_last) r_busy <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_last <= w_last;
            if (r_diag) begin
                r_o_column <= r_row;
                r_o_kind   <= KIND_DIAG;
                r_o_coup   <= r_coup;
                r_o_field  <= r_field;
            end else begin
                r_o_column <= r_row ^ w_flip16;
                r_o_kind   <= KIND_FLIP;
                r_o_coup   <= '0;
                r_o_field  <= '0;
            end
        end
        if (w_take) begin
            r_row   <= i_xfer.info.row;
            r_coup  <= i_xfer.info.coupling;
            r_field <= i_xfer.info.field;
            r_pa    <= w_in_rowv;
            r_pb    <= ~w_in_rowv & w_in_nmask;
        end else if (w_emit && !r_diag) begin
            if (w_pa_any) r_pa <= w_pa_nxt;
            else          r_pb <= w_pb_nxt;
        end
    end

    assign o_res.valid          = r_o_valid;
    assign o_res.column         = r_o_column;
    assign o_res.entry_kind     = r_o_kind;
    assign o_res.coupling_value = r_o_coup;
    assign o_res.field_value    = r_o_field;
    assign o_res.last_of_row    = r_o_last;

endmodule
